// File: rtl/wbr_pkg.sv
// wbr_pkg: shared constants and types of the wheel bitmap repacker
`default_nettype none
package wbr_pkg;

  localparam int MAX_BLOCK_BYTES = 1024;
  localparam int PAT_AW          = $clog2(MAX_BLOCK_BYTES);
  localparam int LEN_W           = 11;
  localparam int BYTE_W          = 8;
  localparam int ACC_W           = 15;
  localparam int FILL_W          = 4;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = LEN_W;
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_AW         = $clog2(FIFO_DEPTH);

  localparam logic [LEN_W-1:0] BLOCK_BYTES_RST = LEN_W'(7);
  localparam logic [LEN_W-1:0] MAX_LEN         = LEN_W'(MAX_BLOCK_BYTES);

  // input item function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_DATA = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CLEAR = 1'd1;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_block;
  } res_t;

endpackage
`default_nettype wire

// File: rtl/wbr_ifs.sv
// wbr_ifs: valid/ready channel interfaces of the wheel bitmap repacker
`default_nettype none
interface wbr_in_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [wbr_pkg::PAT_AW-1:0] pattern_addr;
  logic [wbr_pkg::BYTE_W-1:0] data_byte;

  modport source (output valid, output func, output pattern_addr, output data_byte,
                  input ready);
  modport sink   (input valid, input func, input pattern_addr, input data_byte,
                  output ready);
endinterface

interface wbr_out_if;
  logic                       valid;
  logic                       ready;
  logic [wbr_pkg::BYTE_W-1:0] out_byte;
  logic                       last_of_block;

  modport source (output valid, output out_byte, output last_of_block, input ready);
  modport sink   (input valid, input out_byte, input last_of_block, output ready);
endinterface

interface wbr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [wbr_pkg::CFG_IDX_W-1:0]  index;
  logic [wbr_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/wheel_bitmap_repacker_core.sv
// wheel_bitmap_repacker_core: wheel-30 to larger-wheel bitmap repacker, top level
//
//   channel   dir  transfer carries                          notes
//   in_s      in   func, pattern_addr, data_byte             load or data byte
//   out_s     out  out_byte, last_of_block                   packed result byte
//   cfg_s     in   index, data                               always ready
//
// one input item per cycle sustained while the result buffer has room; a data
// byte's pattern is read and registered at its transfer, then extracted and
// accumulated; the pattern memory's single read port sets the first stage, the
// accumulator update the second; results queue in a four entry buffer
// input stalls only while the result buffer has fewer than two free slots
// synchronous active-low reset clears control state; the pattern memory is
// not cleared and needs no clearing pass
`default_nettype none
module wheel_bitmap_repacker_core (
  input  wire logic clk,
  input  wire logic rst_n,
  wbr_in_if.sink    in_s,
  wbr_out_if.source out_s,
  wbr_cfg_if.sink   cfg_s
);
  import wbr_pkg::*;

  // parallel bit extract of d under mask m, lsb first, with kept bit count
  function automatic logic [BYTE_W+FILL_W-1:0] pext8(input logic [BYTE_W-1:0] d,
                                                     input logic [BYTE_W-1:0] m);
    logic [BYTE_W-1:0] r;
    logic [FILL_W-1:0] k;
    r = '0;
    k = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      if (m[i]) begin
        r[k[2:0]] = d[i];
        k = k + FILL_W'(1);
      end
    end
    return {k, r};
  endfunction

  // configuration registers
  logic [LEN_W-1:0]  block_bytes_r;
  logic [BYTE_W-1:0] first_clear_r;

  // stage 0: block position and first block flag, tracked at transfer
  logic [PAT_AW-1:0] pos_r, pos_nxt;
  logic              first_r, first_nxt;

  // pattern memory and its registered read data
  logic [BYTE_W-1:0] pat_mem [MAX_BLOCK_BYTES];
  logic [BYTE_W-1:0] pat_rd_r;

  // stage 1 payload and control
  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_data_r;
  logic              s1_end_r;

  // accumulator
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  // result buffer
  res_t              fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;

  logic              in_fire, data_fire, load_fire, s1_fire, pop;
  logic [LEN_W-1:0]  len_eff;
  logic              blk_end;
  logic [BYTE_W-1:0] data_masked;

  logic [BYTE_W+FILL_W-1:0] ext_all;
  logic [BYTE_W-1:0]        ext;
  logic [FILL_W-1:0]        ext_cnt;
  logic [ACC_W-1:0]         acc_sum, acc_sh;
  logic [FILL_W-1:0]        fill_sum, fill_sh;
  logic                     push0, push1;
  res_t                     res0, res1;
  logic [1:0]               push_n;

  // ---------------- configuration port ----------------
  assign cfg_s.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_bytes_r <= BLOCK_BYTES_RST;
      first_clear_r <= '0;
    end else if (cfg_s.valid) begin
      unique case (cfg_s.index)
        CFG_BLOCK_BYTES: block_bytes_r <= cfg_s.data;
        CFG_FIRST_CLEAR: first_clear_r <= cfg_s.data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage 0: transfer and pattern read ----------------
  // the second stage frees its slot when the buffer can take two results
  assign s1_fire   = s1_valid_r && (cnt_r <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
  assign in_s.ready = !s1_valid_r || s1_fire;
  assign in_fire   = in_s.valid && in_s.ready;
  assign data_fire = in_fire && (in_s.func == FUNC_DATA);
  assign load_fire = in_fire && (in_s.func == FUNC_LOAD);

  // zero length acts as one, anything beyond the table as the table size
  always_comb begin
    if (block_bytes_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (block_bytes_r > MAX_LEN) begin
      len_eff = MAX_LEN;
    end else begin
      len_eff = block_bytes_r;
    end
  end

  assign blk_end = ({1'b0, pos_r} + LEN_W'(1)) >= len_eff;

  // the clear mask applies to the first byte of the first block only
  assign data_masked = (first_r && pos_r == '0) ? (in_s.data_byte & ~first_clear_r)
                                                : in_s.data_byte;

  always_comb begin
    pos_nxt   = pos_r;
    first_nxt = first_r;
    if (data_fire) begin
      if (blk_end) begin
        pos_nxt   = '0;
        first_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r + PAT_AW'(1);
      end
    end
  end

  // read is registered in the same edge as the transfer, so a load just
  // before is already visible and no forwarding is needed
  always_ff @(posedge clk) begin
    if (load_fire) begin
      pat_mem[in_s.pattern_addr] <= in_s.data_byte;
    end
    if (data_fire) begin
      pat_rd_r <= pat_mem[pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (data_fire) begin
      s1_data_r <= data_masked;
      s1_end_r  <= blk_end;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    if (data_fire) begin
      s1_valid_nxt = 1'b1;
    end
  end

  // ---------------- stage 1: extract and accumulate ----------------
  assign ext_all = pext8(s1_data_r, pat_rd_r);
  assign ext     = ext_all[BYTE_W-1:0];
  assign ext_cnt = ext_all[BYTE_W+FILL_W-1:BYTE_W];

  // fill stays below eight between items, so the shifted byte fits 15 bits
  assign acc_sum  = acc_r | (ACC_W'(ext) << fill_r[2:0]);
  assign fill_sum = fill_r + ext_cnt;

  always_comb begin
    push0   = 1'b0;
    push1   = 1'b0;
    res0    = '0;
    res1    = '0;
    acc_sh  = acc_sum;
    fill_sh = fill_sum;
    if (fill_sum >= FILL_W'(BYTE_W)) begin
      push0              = 1'b1;
      res0.out_byte      = acc_sum[BYTE_W-1:0];
      res0.last_of_block = s1_end_r && (fill_sum == FILL_W'(BYTE_W));
      acc_sh             = acc_sum >> BYTE_W;
      fill_sh            = fill_sum - FILL_W'(BYTE_W);
    end
    // partial byte flush at block end, zero filled above the valid bits
    if (s1_end_r && fill_sh != '0) begin
      if (push0) begin
        push1              = 1'b1;
        res1.out_byte      = acc_sh[BYTE_W-1:0];
        res1.last_of_block = 1'b1;
      end else begin
        push0              = 1'b1;
        res0.out_byte      = acc_sh[BYTE_W-1:0];
        res0.last_of_block = 1'b1;
      end
    end
  end

  always_comb begin
    acc_nxt  = acc_r;
    fill_nxt = fill_r;
    if (s1_fire) begin
      if (s1_end_r) begin
        acc_nxt  = '0;
        fill_nxt = '0;
      end else begin
        acc_nxt  = acc_sh;
        fill_nxt = fill_sh;
      end
    end
  end

  // ---------------- result buffer ----------------
  assign pop    = out_s.valid && out_s.ready;
  assign push_n = s1_fire ? ({1'b0, push0} + {1'b0, push1}) : 2'd0;

  always_comb begin
    head_nxt = pop ? head_r + FIFO_AW'(1) : head_r;
    tail_nxt = tail_r + FIFO_AW'(push_n);
    cnt_nxt  = cnt_r + (FIFO_AW+1)'(push_n) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (s1_fire && push0) begin
      fifo_r[tail_r] <= res0;
    end
    if (s1_fire && push1) begin
      fifo_r[tail_r + FIFO_AW'(1)] <= res1;
    end
  end

  assign out_s.valid         = (cnt_r != '0);
  assign out_s.out_byte      = fifo_r[head_r].out_byte;
  assign out_s.last_of_block = fifo_r[head_r].last_of_block;

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      first_r    <= 1'b1;
      s1_valid_r <= 1'b0;
      acc_r      <= '0;
      fill_r     <= '0;
      head_r     <= '0;
      tail_r     <= '0;
      cnt_r      <= '0;
    end else begin
      pos_r      <= pos_nxt;
      first_r    <= first_nxt;
      s1_valid_r <= s1_valid_nxt;
      acc_r      <= acc_nxt;
      fill_r     <= fill_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  // ---------------- assertions ----------------
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("result buffer overfilled");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < FILL_W'(BYTE_W))
    else $error("accumulator holds a full byte between items");

  a_block_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_end_r) |=> (fill_r == '0 && acc_r == '0))
    else $error("accumulator not cleared at block end");

  a_pos_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (data_fire && blk_end) |=> (pos_r == '0 && !first_r))
    else $error("block position not restarted at block end");

  a_two_results_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && push1) |-> (s1_end_r && !res0.last_of_block))
    else $error("second result outside a block end");

endmodule
`default_nettype wire
